FILE: rtl/near_white_border_crop_finder_unit_assert.svh
// Assertion macros for the crop finder checker.
`ifndef NEAR_WHITE_BORDER_CROP_FINDER_UNIT_ASSERT_SVH
`define NEAR_WHITE_BORDER_CROP_FINDER_UNIT_ASSERT_SVH
// a implies b on the next edge
`define NWB_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
// a implies b on the same edge
`define NWB_ASSERT_NOW(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`endif

FILE: rtl/nwbcf_pkg.sv
// Shared types and constants for the crop finder.
package nwbcf_pkg;
  localparam int unsigned MAX_WIDTH_DEF  = 2048;
  localparam int unsigned MAX_HEIGHT_DEF = 2048;
  localparam int unsigned NUM_REGS = 7;

  typedef enum logic [2:0] {
    REG_WIDTH   = 3'd0,
    REG_HEIGHT  = 3'd1,
    REG_THRESH  = 3'd2,
    REG_MIN_W   = 3'd3,
    REG_MAX_W   = 3'd4,
    REG_MIN_H   = 3'd5,
    REG_MAX_H   = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ROWS     = 3'd1,
    ST_COLS     = 3'd2,
    ST_DEGEN    = 3'd3,
    ST_NARROW   = 3'd4,
    ST_WIDE     = 3'd5,
    ST_SHORT    = 3'd6,
    ST_TALL     = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DRAIN,
    BK_OUT
  } back_state_t;

  // Row summary handed from the front to the back at frame end.
  typedef struct packed {
    logic        row_seen;
    logic [10:0] top;
    logic [10:0] bottom;
  } frame_info_t;
endpackage

FILE: rtl/nwbcf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module nwbcf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/nwbcf_front.sv
// Front end: accepts pixels, sums rows, updates column sums in RAM.
module nwbcf_front #(
  parameter int unsigned MAX_WIDTH  = nwbcf_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = nwbcf_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned CW = $clog2(MAX_WIDTH),
  parameter int unsigned SW = 8 + $clog2(MAX_HEIGHT)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pix_valid,
  output logic                 pix_stall,
  input  logic [7:0]           pix,
  input  logic                 restart,
  input  logic [CW:0]          width,
  input  logic [$clog2(MAX_HEIGHT):0] height,
  input  logic [7:0]           thresh,
  // column RAM write side
  output logic                 ram_we,
  output logic [CW-1:0]        ram_waddr,
  output logic [SW-1:0]        ram_wdata,
  output logic [CW-1:0]        ram_raddr,
  input  logic [SW-1:0]        ram_rdata,
  // frame done handoff
  input  logic                 back_busy,
  output logic                 done_valid,
  output nwbcf_pkg::frame_info_t done_info
);
  import nwbcf_pkg::*;
  localparam int unsigned HW = $clog2(MAX_HEIGHT);
  localparam int unsigned RW = 8 + CW;

  logic [CW-1:0] col;
  logic [HW-1:0] row;
  logic [RW-1:0] row_sum;
  logic          row_seen;
  logic [10:0]   top, bottom;
  // pipeline stage for read-modify-write
  logic          p_valid;
  logic [CW-1:0] p_col;
  logic          p_first;
  logic [7:0]    p_pix;
  logic          acc;
  logic          end_row, end_frame;
  logic [RW+8:0] row_lim;
  logic [RW-1:0] row_tot;
  logic          is_content;

  assign pix_stall = back_busy;
  assign acc = pix_valid && !pix_stall;
  assign end_row = ({1'b0, col} + 1'b1) >= width;
  assign end_frame = end_row && (({1'b0, row} + 1'b1) >= height);
  assign row_tot = row_sum + RW'(pix);
  assign row_lim = (RW+9)'(thresh) * (RW+9)'(width);
  assign is_content = (RW+9)'(row_tot) <= row_lim;
  assign ram_raddr = col;

  // forward the just-written value when the same column is read back
  logic [SW-1:0] old;
  logic          fwd;
  logic [SW-1:0] last_wdata;
  assign old = fwd ? last_wdata : ram_rdata;
  assign ram_we = p_valid;
  assign ram_waddr = p_col;
  assign ram_wdata = p_first ? SW'(p_pix) : old + SW'(p_pix);

  always_ff @(posedge clk) begin
    p_col   <= col;
    p_first <= (row == '0);
    p_pix   <= pix;
    // a write lands on the same edge as the read of the same column
    fwd        <= p_valid && (p_col == col);
    last_wdata <= ram_wdata;
    if (rst || restart) begin
      col <= '0; row <= '0; row_sum <= '0; row_seen <= 1'b0;
      top <= '0; bottom <= '0; p_valid <= 1'b0; done_valid <= 1'b0;
    end else begin
      p_valid <= acc;
      done_valid <= 1'b0;
      if (acc) begin
        if (end_row) begin
          col <= '0;
          row_sum <= '0;
          if (end_frame) begin
            row <= '0;
            row_seen <= 1'b0;
            top <= '0; bottom <= '0;
            done_valid <= 1'b1;
            done_info.row_seen <= row_seen || is_content;
            done_info.top <= (!row_seen && is_content) ? 11'(row) : top;
            done_info.bottom <= is_content ? 11'(row) : bottom;
          end else begin
            row <= row + 1'b1;
            if (is_content) begin
              if (!row_seen) top <= 11'(row);
              bottom <= 11'(row);
              row_seen <= 1'b1;
            end
          end
        end else begin
          col <= col + 1'b1;
          row_sum <= row_tot;
        end
      end
    end
  end
endmodule

FILE: rtl/nwbcf_back.sv
// Back end: scans column sums at frame end and forms the result.
module nwbcf_back #(
  parameter int unsigned MAX_WIDTH  = nwbcf_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = nwbcf_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned CW = $clog2(MAX_WIDTH),
  parameter int unsigned SW = 8 + $clog2(MAX_HEIGHT)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 done_valid,
  input  nwbcf_pkg::frame_info_t done_info,
  input  logic [CW:0]          width,
  input  logic [$clog2(MAX_HEIGHT):0] height,
  input  logic [7:0]           thresh,
  input  logic [11:0]          min_w, max_w, min_h, max_h,
  output logic                 busy,
  output logic                 scan_active,
  output logic [CW-1:0]        scan_addr,
  input  logic [SW-1:0]        ram_rdata,
  output logic                 res_valid,
  input  logic                 res_stall,
  output logic [2:0]           status,
  output logic [10:0]          top_row, bottom_row, left_col, right_col,
  output logic [11:0]          crop_width, crop_height
);
  import nwbcf_pkg::*;

  back_state_t   state, state_next;
  frame_info_t   info;
  logic [CW:0]   addr;       // next address to read
  logic [CW:0]   chk;        // column whose data arrives this cycle
  logic          chk_v;
  logic          col_seen;
  logic [10:0]   left, right;
  logic [SW+8:0] col_lim;
  logic          col_content;
  logic [11:0]   cw, ch;

  assign busy = (state != BK_IDLE);
  assign scan_active = (state == BK_SCAN) || (state == BK_DRAIN);
  assign scan_addr = addr[CW-1:0];
  assign col_lim = (SW+9)'(thresh) * (SW+9)'(height);
  assign col_content = (SW+9)'(ram_rdata) <= col_lim;
  assign res_valid = (state == BK_OUT);
  assign cw = 12'(right) - 12'(left) + 12'd1;
  assign ch = 12'(info.bottom) - 12'(info.top) + 12'd1;

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE:  if (done_valid) state_next = BK_SCAN;
      BK_SCAN:  if (addr + 1'b1 >= width) state_next = BK_DRAIN;
      BK_DRAIN: if (!chk_v) state_next = BK_OUT;
      BK_OUT:   if (!res_stall) state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chk_v <= 1'b0; addr <= '0; col_seen <= 1'b0;
    end else begin
      chk_v <= (state == BK_SCAN);
      chk <= addr;
      if (state == BK_IDLE && done_valid) begin
        info <= done_info; addr <= '0; col_seen <= 1'b0;
        left <= '0; right <= '0;
      end
      if (state == BK_SCAN) addr <= addr + 1'b1;
      if (chk_v && col_content && info.row_seen) begin
        if (!col_seen) left <= 11'(chk);
        right <= 11'(chk);
        col_seen <= 1'b1;
      end
    end
  end

  always_comb begin
    top_row = 11'd0; bottom_row = 11'd0; left_col = 11'd0; right_col = 11'd0;
    crop_width = 12'd0; crop_height = 12'd0;
    if (!info.row_seen) status = ST_ROWS;
    else begin
      top_row = info.top; bottom_row = info.bottom; crop_height = ch;
      if (!col_seen) status = ST_COLS;
      else begin
        left_col = left; right_col = right; crop_width = cw;
        if (right <= left || info.bottom <= info.top) status = ST_DEGEN;
        else if (cw < min_w) status = ST_NARROW;
        else if (cw > max_w) status = ST_WIDE;
        else if (ch < min_h) status = ST_SHORT;
        else if (ch > max_h) status = ST_TALL;
        else status = ST_OK;
      end
    end
  end
endmodule

FILE: rtl/near_white_border_crop_finder_unit.sv
// Top level of the near-white border crop finder.
//  channel | valid       | stall       | payload
//  pixel   | pixel_valid | pixel_stall | pixel
//  result  | res_valid   | res_stall   | status .. crop_height
//  config  | cfg_we      | -           | cfg_index, cfg_data
// One pixel per cycle while no frame-end scan runs; the column-sum RAM
// takes one read-modify-write per pixel, pipelined one stage deep.
// After the last pixel the column scan reads the RAM once per column
// while pixel_stall is high, then the result waits in its register until
// taken. Reset is synchronous; column RAM needs none.
module near_white_border_crop_finder_unit #(
  parameter int unsigned MAX_WIDTH  = nwbcf_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = nwbcf_pkg::MAX_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        pixel_valid,
  output logic        pixel_stall,
  input  logic [7:0]  pixel,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [2:0]  status,
  output logic [10:0] top_row,
  output logic [10:0] bottom_row,
  output logic [10:0] left_col,
  output logic [10:0] right_col,
  output logic [11:0] crop_width,
  output logic [11:0] crop_height,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data
);
  import nwbcf_pkg::*;
  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned HW = $clog2(MAX_HEIGHT);
  localparam int unsigned SW = 8 + HW;

  logic [11:0] r_w, r_h, r_minw, r_maxw, r_minh, r_maxh;
  logic [7:0]  r_thr;
  logic        restart;
  logic [CW:0] width;
  logic [HW:0] height;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_w <= 12'd2048; r_h <= 12'd2048; r_thr <= 8'd250;
      r_minw <= 12'd196; r_maxw <= 12'd800; r_minh <= 12'd196; r_maxh <= 12'd1000;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_WIDTH:  r_w <= cfg_data;
        REG_HEIGHT: r_h <= cfg_data;
        REG_THRESH: r_thr <= cfg_data[7:0];
        REG_MIN_W:  r_minw <= cfg_data;
        REG_MAX_W:  r_maxw <= cfg_data;
        REG_MIN_H:  r_minh <= cfg_data;
        REG_MAX_H:  r_maxh <= cfg_data;
        default: ;
      endcase
    end
  end
  assign restart = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

  // clamp geometry: zero acts as one, large saturates to the limit
  always_comb begin
    if (r_w == 12'd0) width = (CW+1)'(1);
    else if (32'(r_w) > MAX_WIDTH) width = (CW+1)'(MAX_WIDTH);
    else width = (CW+1)'(r_w);
    if (r_h == 12'd0) height = (HW+1)'(1);
    else if (32'(r_h) > MAX_HEIGHT) height = (HW+1)'(MAX_HEIGHT);
    else height = (HW+1)'(r_h);
  end

  logic          ram_we, back_busy, scan_active, done_valid;
  logic [CW-1:0] ram_waddr, f_raddr, b_raddr, raddr;
  logic [SW-1:0] ram_wdata, ram_rdata;
  frame_info_t   done_info;

  assign raddr = scan_active ? b_raddr : f_raddr;

  nwbcf_ram #(.WIDTH(SW), .DEPTH(MAX_WIDTH)) u_ram (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(raddr), .rdata(ram_rdata)
  );

  nwbcf_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk, .rst, .pix_valid(pixel_valid), .pix_stall(pixel_stall), .pix(pixel),
    .restart, .width, .height, .thresh(r_thr),
    .ram_we, .ram_waddr, .ram_wdata, .ram_raddr(f_raddr), .ram_rdata,
    .back_busy(back_busy || done_valid), .done_valid, .done_info
  );

  nwbcf_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
    .clk, .rst, .done_valid, .done_info, .width, .height, .thresh(r_thr),
    .min_w(r_minw), .max_w(r_maxw), .min_h(r_minh), .max_h(r_maxh),
    .busy(back_busy), .scan_active, .scan_addr(b_raddr), .ram_rdata,
    .res_valid, .res_stall, .status, .top_row, .bottom_row, .left_col,
    .right_col, .crop_width, .crop_height
  );
endmodule

FILE: rtl/nwbcf_checker.sv
// Port-level checker for the crop finder, bound to the top level.
`include "near_white_border_crop_finder_unit_assert.svh"
module nwbcf_checker (
  input logic        clk,
  input logic        rst,
  input logic        pixel_valid,
  input logic        pixel_stall,
  input logic        res_valid,
  input logic        res_stall,
  input logic [2:0]  status,
  input logic [10:0] top_row,
  input logic [10:0] bottom_row,
  input logic [11:0] crop_width,
  input logic [11:0] crop_height
);
  import nwbcf_pkg::*;
  // a waiting result holds
  `NWB_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && res_stall, res_valid && $stable(status))
  // no pixels are taken while a result waits
  `NWB_ASSERT_NOW(a_no_pix, clk, rst, res_valid, pixel_stall)
  // rows blank reports a zero height
  `NWB_ASSERT_NOW(a_blank, clk, rst, res_valid && status == ST_ROWS, crop_height == 12'd0)
  // a row window never inverts
  `NWB_ASSERT_NOW(a_order, clk, rst, res_valid && status != ST_ROWS, bottom_row >= top_row)
endmodule

bind near_white_border_crop_finder_unit nwbcf_checker u_chk (
  .clk, .rst, .pixel_valid, .pixel_stall, .res_valid, .res_stall, .status,
  .top_row, .bottom_row, .crop_width, .crop_height
);
